/* src/tcce_pkg.sv */
// shared types and constants of the text console character engine
package tcce_pkg;

   localparam int POS_W       = 11;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int CELL_W      = 2 * BYTE_W;

   // command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_ATTR    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CURSOR = 1'b1;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h07;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] char_code;
      logic [POS_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_attr;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RDATA
   } state_type;

endpackage

/* src/tcce_ram.sv */
// generic single write port, single read port ram with registered read
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tcce_pos_split.sv */
// split of a linear cursor position into row and column by reciprocal multiply
module tcce_pos_split
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int ADDR_W = $clog2(CELLS),
   localparam int COL_W  = $clog2(COLUMNS),
   localparam int ROW_W  = $clog2(ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [POS_W-1:0]  pos,
   output logic              busy,
   output logic              done,
   output logic [COL_W-1:0]  col,
   output logic [ROW_W-1:0]  row,
   output logic [ADDR_W-1:0] lin
);

   localparam int EXT_W  = (ADDR_W > POS_W ? ADDR_W : POS_W) + 1;
   // row = (lin * ceil(2^SHIFT / COLUMNS)) >> SHIFT, exact for any lin below 2^ADDR_W
   localparam int SHIFT  = ADDR_W + $clog2(COLUMNS);
   localparam int RCP_W  = ADDR_W + 2;
   localparam int PROD_W = ADDR_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << SHIFT) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ADDR_W-1:0] lin_ff, lin_in;
   logic [ROW_W-1:0]  quot_ff, quot_in;
   logic [ADDR_W-1:0] sat_pos;
   logic [PROD_W-1:0] prod;
   logic [ADDR_W-1:0] row_base;

   // out of range start positions stick to the last cell
   assign sat_pos  = (EXT_W'(pos) >= EXT_W'(CELLS)) ? ADDR_W'(CELLS - 1) : ADDR_W'(pos);
   assign prod     = PROD_W'(lin_ff) * PROD_W'(RECIP);
   assign row_base = ADDR_W'(quot_ff) * ADDR_W'(COLUMNS);

   // load cycle latches the position, next cycle the row, then done
   always_comb begin
      busy_in = load;
      done_in = busy_ff;
      lin_in  = load ? sat_pos : lin_ff;
      quot_in = busy_ff ? ROW_W'(prod >> SHIFT) : quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff  <= lin_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff | done_ff;
   assign done = done_ff;
   assign col  = COL_W'(lin_ff - row_base);
   assign row  = quot_ff;
   assign lin  = lin_ff;

endmodule

/* src/text_console_char_engine.sv */
// top level of the text console character engine
//
// text console over a ROWS x COLUMNS cell store. a word is accepted when start is
// high and busy is low; its result word shows on rsp_word for one cycle with
// rsp_strobe, and the receiver must take it then. between accepts a put passes
// through the exec state and a read through the exec and read-data states. a
// newline, wrap or tab past the end on the last row also blanks the new bottom
// row, and a form feed blanks the whole store. after reset busy stays high while
// the store is cleared to spaces; register writes are taken during that time. a
// start_cursor write holds busy while the position is split into row and column.
// scrolling never moves cells: the store is a ring of rows and a top-row
// offset picks the row shown first
module text_console_char_engine
   import tcce_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_word,
   output logic                   rsp_strobe,
   output rsp_type                rsp_word,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int COLI_W = COL_W + 1;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int TAB_W  = $clog2(COLUMNS + TAB_STOP);
   localparam int EXT_W  = (ADDR_W > POS_W ? ADDR_W : POS_W) + 1;

   // control state
   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] lin_ff, lin_in;      // cursor as row*COLUMNS+col
   logic [ADDR_W-1:0] top_ff, top_in;      // address of the row shown at the top
   logic [BYTE_W-1:0] attr_ff, attr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] clr_last_ff, clr_last_in;
   logic [BYTE_W-1:0] clr_attr_ff, clr_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   req_type           req_ff, req_in;
   logic [ADDR_W-1:0] phys_ff, phys_in;
   logic              in_range_ff, in_range_in;
   rsp_type           rsp_ff, rsp_in;

   // cell store port
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   // cursor load unit
   logic              split_load;
   logic              split_busy;
   logic              split_done;
   logic [COL_W-1:0]  split_col;
   logic [ROW_W-1:0]  split_row;
   logic [ADDR_W-1:0] split_lin;

   logic              req_accept;
   logic [EXT_W-1:0]  base_ext;
   logic [EXT_W-1:0]  sum_ext;
   logic [ADDR_W-1:0] phys_acc;
   logic              idx_ok;
   logic [ADDR_W-1:0] row_start;
   logic [COLI_W-1:0] col_inc;
   logic [ADDR_W-1:0] top_next;
   logic [TAB_W-1:0]  tab_next [COLUMNS];
   logic [TAB_W-1:0]  tab_col;
   logic              do_lf;

   // next tab stop for each column, built at elaboration
   for (genvar g = 0; g < COLUMNS; g++) begin : g_tab
      assign tab_next[g] = TAB_W'(((g + TAB_STOP) / TAB_STOP) * TAB_STOP);
   end

   assign tab_col    = tab_next[col_ff];
   assign row_start  = lin_ff - ADDR_W'(col_ff);
   assign col_inc    = COLI_W'(col_ff) + 1'b1;
   assign top_next   = (top_ff == ADDR_W'(CELLS - COLUMNS)) ? '0
                                                            : top_ff + ADDR_W'(COLUMNS);

   assign busy       = (state_ff != ST_IDLE) || split_busy;
   assign req_accept = start && !busy;
   assign split_load = csr_write_en && (csr_index == CSR_START_CURSOR);

   // logical position to store address: add the top-row offset, wrap once
   assign base_ext = (req_word.cmd == CMD_READ) ? EXT_W'(req_word.read_index)
                                                : EXT_W'(lin_ff);
   assign sum_ext  = base_ext + EXT_W'(top_ff);
   assign phys_acc = (sum_ext >= EXT_W'(CELLS)) ? ADDR_W'(sum_ext - EXT_W'(CELLS))
                                                : ADDR_W'(sum_ext);
   assign idx_ok   = EXT_W'(req_word.read_index) < EXT_W'(CELLS);

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tcce_pos_split #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_split (
      .clock (clock),
      .reset (reset),
      .load  (split_load),
      .pos   (csr_wdata),
      .busy  (split_busy),
      .done  (split_done),
      .col   (split_col),
      .row   (split_row),
      .lin   (split_lin)
   );

   // one item at a time: the store is never read and written for the same
   // item in the same cycle, so no forwarding path is needed
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lin_in       = lin_ff;
      top_in       = top_ff;
      attr_in      = attr_ff;
      clr_addr_in  = clr_addr_ff;
      clr_last_in  = clr_last_ff;
      clr_attr_in  = clr_attr_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      phys_in      = phys_ff;
      in_range_in  = in_range_ff;
      rsp_in       = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = {clr_attr_ff, CHAR_SPACE};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = phys_ff;
      do_lf        = 1'b0;

      if (csr_write_en && (csr_index == CSR_TEXT_ATTR)) begin
         attr_in = csr_wdata[BYTE_W-1:0];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // blank sweep, one cell per cycle
            ram_wr_en = 1'b1;
            if (clr_addr_ff == clr_last_ff) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in      = req_word;
               phys_in     = phys_acc;
               in_range_in = idx_ok;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.cmd == CMD_READ) begin
               ram_rd_en = 1'b1;
               state_in  = ST_RDATA;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               unique case (req_ff.char_code)
                  CHAR_LF: begin
                     do_lf = 1'b1;
                  end
                  CHAR_FF: begin
                     col_in      = '0;
                     row_in      = '0;
                     lin_in      = '0;
                     top_in      = '0;
                     clr_addr_in = '0;
                     clr_last_in = ADDR_W'(CELLS - 1);
                     clr_attr_in = attr_ff;
                     state_in    = ST_CLEAR;
                  end
                  CHAR_BS: begin
                     // no erase, and no move at the left edge
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                        lin_in = lin_ff - 1'b1;
                     end
                  end
                  CHAR_CR: begin
                     col_in = '0;
                     lin_in = row_start;
                  end
                  CHAR_TAB: begin
                     if (tab_col >= TAB_W'(COLUMNS)) begin
                        do_lf = 1'b1;
                     end else begin
                        col_in = COL_W'(tab_col);
                        lin_in = row_start + ADDR_W'(tab_col);
                     end
                  end
                  default: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = phys_ff;
                     ram_wr_data = {attr_ff, req_ff.char_code};
                     if (col_inc >= COLI_W'(COLUMNS)) begin
                        do_lf = 1'b1;
                     end else begin
                        col_in = COL_W'(col_inc);
                        lin_in = lin_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_RDATA: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (in_range_ff) begin
               rsp_in.cell_char = ram_rd_data[BYTE_W-1:0];
               rsp_in.cell_attr = ram_rd_data[CELL_W-1:BYTE_W];
            end
         end
      endcase

      // line feed: on the last row the top row rolls to the bottom and is blanked
      if (do_lf) begin
         col_in = '0;
         if (row_ff == ROW_W'(ROWS - 1)) begin
            lin_in      = ADDR_W'(CELLS - COLUMNS);
            top_in      = top_next;
            clr_addr_in = top_ff;
            clr_last_in = top_ff + ADDR_W'(COLUMNS - 1);
            clr_attr_in = attr_ff;
            state_in    = ST_CLEAR;
         end else begin
            row_in = row_ff + 1'b1;
            lin_in = row_start + ADDR_W'(COLUMNS);
         end
      end

      rsp_in.cursor_pos = POS_W'(lin_in);

      // cursor load from the start register
      if (split_done) begin
         col_in = split_col;
         row_in = split_row;
         lin_in = split_lin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         top_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         clr_addr_ff  <= '0;
         clr_last_ff  <= ADDR_W'(CELLS - 1);
         clr_attr_ff  <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lin_ff       <= lin_in;
         top_ff       <= top_in;
         attr_ff      <= attr_in;
         clr_addr_ff  <= clr_addr_in;
         clr_last_ff  <= clr_last_in;
         clr_attr_ff  <= clr_attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      phys_ff     <= phys_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two cycles in a row");

   a_cursor_lin: assert property (@(posedge clock) disable iff (reset)
      int'(lin_ff) == int'(row_ff) * COLUMNS + int'(col_ff))
      else $error("linear cursor out of step with row and column");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      int'(col_ff) < COLUMNS && int'(row_ff) < ROWS)
      else $error("cursor outside the screen");

   a_top_row: assert property (@(posedge clock) disable iff (reset)
      int'(top_ff) < CELLS && (int'(top_ff) % COLUMNS) == 0)
      else $error("top row offset not on a row boundary");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> clr_addr_ff <= clr_last_ff)
      else $error("blank sweep ran past its last cell");
`endif

endmodule

/* tb/sv/tb_text_console_char_engine.sv */
// self-checking testbench of the text console character engine
module tb_text_console_char_engine;
   import tcce_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // screen geometry, the block runs with its default parameters
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int TAB   = 8;
   localparam int CELLS = COLS * ROWS;

   // run sizing
   localparam int PHASES      = 4;
   localparam int PHASE_WORDS = 300;
   localparam int MAX_REPORTS = 10;
   // worst case: every word a form feed plus the longest sender gap, and the
   // clearing pass after reset, taken about five times over
   localparam int RUN_LIMIT   = 12_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;
   logic    csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TEXT_ATTR;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // a directed word may carry a reply typed in by hand; it rides along
   // with req_word so the checker picks it up at the accepting edge
   logic    req_known = 1'b0;
   rsp_type req_want  = '0;

   text_console_char_engine uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_word     (req_word),
      .rsp_strobe   (rsp_strobe),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // console shadow: cell store, cursor and attribute as the block should
   // hold them, advanced once per accepted word
   // ------------------------------------------------------------------
   logic [CELL_W-1:0] cells [CELLS];
   logic [6:0]        cur_col;
   logic [4:0]        cur_row;
   logic [BYTE_W-1:0] cur_attr;

   rsp_type screen_replies [$];   // replies the block still owes, oldest first

   int cycles           = 0;
   int words_sent       = 0;
   int replies_checked  = 0;
   int mismatches       = 0;
   int scrolls          = 0;
   int clears           = 0;
   int reads            = 0;
   int reads_off_screen = 0;

   function automatic void load_cursor(input logic [POS_W-1:0] pos);
      int p;
      // positions past the last cell saturate to it
      p = (pos >= CELLS) ? CELLS - 1 : int'(pos);
      cur_col = 7'(p % COLS);
      cur_row = 5'(p / COLS);
   endfunction

   function automatic void new_line();
      cur_col = '0;
      if (cur_row == ROWS - 1) begin
         // bottom row: everything moves up one row, new bottom row blanked
         for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = {cur_attr, CHAR_SPACE};
         scrolls++;
      end else begin
         cur_row++;
      end
   endfunction

   function automatic rsp_type console_apply(input req_type w);
      rsp_type r;
      int      tab_col;
      r = '0;
      if (w.cmd == CMD_READ) begin
         reads++;
         if (w.read_index < CELLS) begin
            r.cell_char = cells[w.read_index][BYTE_W-1:0];
            r.cell_attr = cells[w.read_index][CELL_W-1:BYTE_W];
         end else begin
            // off-screen index reads back zero, nothing moves
            reads_off_screen++;
         end
      end else begin
         case (w.char_code)
            CHAR_LF: begin
               new_line();
            end
            CHAR_FF: begin
               for (int i = 0; i < CELLS; i++) cells[i] = {cur_attr, CHAR_SPACE};
               cur_col = '0;
               cur_row = '0;
               clears++;
            end
            CHAR_BS: begin
               // no erase, and no step back past column zero
               if (cur_col > 0) cur_col--;
            end
            CHAR_CR: begin
               cur_col = '0;
            end
            CHAR_TAB: begin
               tab_col = ((int'(cur_col) + TAB) / TAB) * TAB;
               if (tab_col >= COLS) new_line();
               else cur_col = 7'(tab_col);
            end
            default: begin
               cells[int'(cur_row) * COLS + int'(cur_col)] = {cur_attr, w.char_code};
               if (int'(cur_col) + 1 >= COLS) new_line();
               else cur_col++;
            end
         endcase
      end
      r.cursor_pos = POS_W'(int'(cur_row) * COLS + int'(cur_col));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // checker: everything happens at the rising edge from values sampled
   // before the edge, so acceptance, register writes and replies of one
   // edge are handled in a fixed order by this one process
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) cells[i] = {RESET_ATTR, CHAR_SPACE};
         cur_attr = RESET_ATTR;
         load_cursor('0);
         screen_replies.delete();
      end else begin
         // register writes only happen while nothing is in flight
         if (csr_write_en === 1'b1) begin
            case (csr_index)
               CSR_TEXT_ATTR:    cur_attr = csr_wdata[BYTE_W-1:0];
               CSR_START_CURSOR: load_cursor(csr_wdata[POS_W-1:0]);
               default: ;
            endcase
         end
         // word accepted: run the shadow first, a hand-typed reply wins
         if (start === 1'b1 && busy === 1'b0) begin
            want = console_apply(req_word);
            if (req_known) want = req_want;
            screen_replies.push_back(want);
         end
         // reply out: compare with the oldest one owed
         if (rsp_strobe === 1'b1) begin
            got = rsp_word;
            if (screen_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: reply with none owed: cursor %0d char %02h attr %02h",
                           $realtime, got.cursor_pos, got.cell_char, got.cell_attr);
            end else begin
               want = screen_replies.pop_front();
               replies_checked++;
               if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
                   got.cell_attr !== want.cell_attr) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: reply %0d: cursor %0d/%0d char %02h/%02h attr %02h/%02h %s",
                              $realtime, replies_checked, want.cursor_pos, got.cursor_pos,
                              want.cell_char, got.cell_char, want.cell_attr, got.cell_attr,
                              "(expected/actual)");
               end
            end
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // driver
   // ------------------------------------------------------------------
   int idle_pct   = 0;   // chance in a hundred of a gap before a word
   int burst_left = 0;   // words still to go back to back

   // lower start, then wait at falling edges until every reply is in and
   // busy is low (covers the clearing pass and trailing row blanking);
   // returns on a rising edge
   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (screen_replies.size() != 0 || busy !== 1'b0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_word(input req_type w, input bit known, input rsp_type want);
      int gap;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if ($urandom_range(99) < idle_pct) begin
         // mostly short gaps, now and then a long one
         gap = ($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      end else if ($urandom_range(99) < 3) begin
         burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_word  <= w;
      req_known <= known;
      req_want  <= want;
      // accepted at the first edge with busy low
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
   endtask

   // random word: reads anywhere including off screen, control codes
   // weighted up so the cursor keeps reaching the bottom and scrolling
   function automatic req_type random_word();
      req_type w;
      int      pick;
      w.cmd        = CMD_PUT;
      w.char_code  = BYTE_W'($urandom_range(255));
      w.read_index = POS_W'($urandom_range(2 ** POS_W - 1));
      pick = $urandom_range(999);
      if (pick < 200) begin
         w.cmd = CMD_READ;
         if ($urandom_range(99) < 15)
            w.read_index = POS_W'($urandom_range(2 ** POS_W - 1, CELLS));
         else w.read_index = POS_W'($urandom_range(CELLS - 1));
      end else if (pick < 320) begin
         w.char_code = CHAR_LF;
      end else if (pick < 328) begin
         w.char_code = CHAR_FF;
      end else if (pick < 380) begin
         w.char_code = CHAR_BS;
      end else if (pick < 420) begin
         w.char_code = CHAR_CR;
      end else if (pick < 500) begin
         w.char_code = CHAR_TAB;
      end
      return w;
   endfunction

   // directed table: a row is either a register write or a word, and a
   // word may carry its reply where it is obvious
   typedef struct {
      bit                     is_reg;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      req_type                word;
      bit                     known;
      rsp_type                want;
   } step_row_type;

   step_row_type opening_rows [$];

   function automatic void add_word(input logic cmd, input logic [BYTE_W-1:0] ch,
                                    input logic [POS_W-1:0] idx, input bit known,
                                    input logic [POS_W-1:0] pos,
                                    input logic [BYTE_W-1:0] rd_char,
                                    input logic [BYTE_W-1:0] rd_attr);
      step_row_type r;
      r.is_reg  = 1'b0;
      r.reg_idx = CSR_TEXT_ATTR;
      r.reg_val = '0;
      r.word    = '{cmd: cmd, char_code: ch, read_index: idx};
      r.known   = known;
      r.want    = '{cursor_pos: pos, cell_char: rd_char, cell_attr: rd_attr};
      opening_rows.push_back(r);
   endfunction

   function automatic void add_reg(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      step_row_type r;
      r         = '{default: '0};
      r.is_reg  = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      opening_rows.push_back(r);
   endfunction

   initial begin
      int          phase;
      int          phase_idle [PHASES];
      logic [7:0]  attr_val;
      logic [10:0] cursor_val;
      req_type     w;

      // sender idle per phase: none, 69, none, 33
      phase_idle = '{0, 69, 0, 33};

      // store after reset: spaces with attribute 07, cursor home
      add_word(CMD_READ, 8'h00, 11'd0,    1, 11'd0,    CHAR_SPACE, RESET_ATTR);
      add_word(CMD_READ, 8'hFF, 11'd1999, 1, 11'd0,    CHAR_SPACE, RESET_ATTR);
      // off-screen reads come back zero
      add_word(CMD_READ, 8'h00, 11'd2000, 1, 11'd0,    8'h00, 8'h00);
      add_word(CMD_READ, 8'h00, 11'd2047, 1, 11'd0,    8'h00, 8'h00);
      // printable, backspace twice (second one at column zero)
      add_word(CMD_PUT,  8'h41, 11'd0,    1, 11'd1,    8'h00, 8'h00);
      add_word(CMD_PUT,  CHAR_BS, 11'd0,  1, 11'd0,    8'h00, 8'h00);
      add_word(CMD_PUT,  CHAR_BS, 11'd0,  1, 11'd0,    8'h00, 8'h00);
      // backspace leaves the character in place
      add_word(CMD_READ, 8'h00, 11'd0,    1, 11'd0,    8'h41, RESET_ATTR);
      add_word(CMD_PUT,  CHAR_TAB, 11'd0, 1, 11'd8,    8'h00, 8'h00);
      add_word(CMD_PUT,  CHAR_CR, 11'd0,  1, 11'd0,    8'h00, 8'h00);
      add_word(CMD_PUT,  CHAR_LF, 11'd0,  1, 11'd80,   8'h00, 8'h00);
      // character code extremes are stored as-is
      add_word(CMD_PUT,  8'h00, 11'd0,    1, 11'd81,   8'h00, 8'h00);
      add_word(CMD_PUT,  8'hFF, 11'd0,    1, 11'd82,   8'h00, 8'h00);
      add_word(CMD_READ, 8'h00, 11'd80,   1, 11'd82,   8'h00, RESET_ATTR);
      add_word(CMD_READ, 8'h00, 11'd81,   1, 11'd82,   8'hFF, RESET_ATTR);
      // form feed blanks with the new attribute
      add_reg(CSR_TEXT_ATTR, 11'h0FF);
      add_word(CMD_PUT,  CHAR_FF, 11'd0,  1, 11'd0,    8'h00, 8'h00);
      add_word(CMD_READ, 8'h00, 11'd1999, 1, 11'd0,   CHAR_SPACE, 8'hFF);
      // start position past the end saturates to the last cell; a character
      // there wraps and scrolls
      add_reg(CSR_START_CURSOR, 11'd2047);
      add_word(CMD_PUT,  8'h5A, 11'd0,    1, 11'd1920, 8'h00, 8'h00);
      add_word(CMD_READ, 8'h00, 11'd1919, 1, 11'd1920, 8'h5A, 8'hFF);
      add_word(CMD_READ, 8'h00, 11'd1999, 1, 11'd1920, CHAR_SPACE, 8'hFF);
      // tab off the end of the last row
      add_reg(CSR_START_CURSOR, 11'd1992);
      add_word(CMD_PUT,  CHAR_TAB, 11'd0, 1, 11'd1920, 8'h00, 8'h00);
      // attribute zero, newline on the last row
      add_reg(CSR_TEXT_ATTR, 11'h000);
      add_word(CMD_PUT,  8'h7E, 11'd0,    1, 11'd1921, 8'h00, 8'h00);
      add_word(CMD_READ, 8'h00, 11'd1920, 1, 11'd1921, 8'h7E, 8'h00);
      add_word(CMD_PUT,  CHAR_LF, 11'd0,  1, 11'd1920, 8'h00, 8'h00);
      add_word(CMD_READ, 8'h00, 11'd1840, 1, 11'd1920, 8'h7E, 8'h00);
      // tab inside a row and a space are left to the shadow
      add_word(CMD_PUT,  CHAR_TAB, 11'd0, 0, 11'd0,    8'h00, 8'h00);
      add_word(CMD_PUT,  8'h20, 11'd0,    0, 11'd0,    8'h00, 8'h00);

      // reset held from time zero, released once
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // the block clears its store before it takes the first word
      wait_idle();

      foreach (opening_rows[i]) begin
         if (opening_rows[i].is_reg) begin
            write_reg(opening_rows[i].reg_idx, opening_rows[i].reg_val);
         end else begin
            send_word(opening_rows[i].word, opening_rows[i].known, opening_rows[i].want);
         end
      end

      // random phases, each under its own attribute, start position and idling
      for (phase = 0; phase < PHASES; phase++) begin
         idle_pct   = phase_idle[phase];
         burst_left = 0;
         case (phase)
            0:       attr_val = 8'h00;
            1:       attr_val = 8'hFF;
            default: attr_val = 8'($urandom_range(255));
         endcase
         case (phase)
            0:       cursor_val = 11'd0;
            1:       cursor_val = 11'd1999;
            2:       cursor_val = 11'($urandom_range(2 ** POS_W - 1, CELLS));
            default: cursor_val = 11'($urandom_range(CELLS - 1));
         endcase
         // upper data bits are don't-care for the attribute register
         write_reg(CSR_TEXT_ATTR, {3'($urandom_range(7)), attr_val});
         write_reg(CSR_START_CURSOR, cursor_val);
         repeat (PHASE_WORDS) begin
            w = random_word();
            send_word(w, 1'b0, '0);
         end
      end

      // drain: all replies in and busy low, then watch for stray replies
      wait_idle();
      repeat (4 * COLS) @(posedge clock);

      mismatches += screen_replies.size();
      $display("summary: %0d words in, %0d replies checked, %0d reads (%0d off screen)",
               words_sent, replies_checked, reads, reads_off_screen);
      $display("summary: %0d scrolls, %0d screen clears, %0d mismatches, %0d cycles",
               scrolls, clears, mismatches, cycles);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
src/tcce_pkg.sv
src/tcce_ram.sv
src/tcce_pos_split.sv
src/text_console_char_engine.sv
tb/sv/tb_text_console_char_engine.sv
